/* rtl/bmmc_pkg.sv */
package bmmc_pkg;

  // Sizing of the stores
  localparam int unsigned EXT_BANKS = 16;
  localparam int unsigned ROM_BYTES = 32768;
  localparam int unsigned HALF_BYTES = 32768;
  localparam int unsigned MAIN_AW = 16;
  localparam int unsigned ROM_AW = $clog2(ROM_BYTES);
  localparam int unsigned EXT_AW = $clog2(EXT_BANKS * HALF_BYTES);

  // Operation codes
  localparam logic [2:0] OP_MEM_RD = 3'd0;
  localparam logic [2:0] OP_MEM_WR = 3'd1;
  localparam logic [2:0] OP_IO_WR  = 3'd2;
  localparam logic [2:0] OP_IO_RD  = 3'd3;
  localparam logic [2:0] OP_ROM_LD = 3'd4;

  // I/O pages and register fields
  localparam logic [7:0] PAGE_BANK    = 8'h0b;
  localparam logic [7:0] PAGE_ROM_ON  = 8'h1d;
  localparam logic [7:0] PAGE_ROM_OFF = 8'h1e;
  localparam logic [7:0] BANK_RESET   = 8'h10;
  localparam int unsigned BANK_OFF_BIT = 4;
  localparam logic [7:0] BYTE_NONE    = 8'hff;

  // Where the result byte of an item comes from
  typedef enum logic [2:0] {
    SRC_BYTE,
    SRC_MAIN,
    SRC_ROM,
    SRC_EXT
  } bmmc_src_e;

  // Map state seen by the decoder
  typedef struct packed {
    logic       turbo;
    logic [7:0] bank;
    logic       rom_sel;
  } bmmc_state_t;

  // Decoded commands for one item
  typedef struct packed {
    logic                main_we;
    logic [MAIN_AW-1:0]  main_addr;
    logic                rom_we;
    logic [ROM_AW-1:0]   rom_addr;
    logic                ext_we;
    logic [EXT_AW-1:0]   ext_addr;
    logic [7:0]          wdata;
    logic                bank_we;
    logic                rom_sel_nxt;
    bmmc_src_e           src;
    logic [7:0]          byte_val;
  } bmmc_cmd_t;

endpackage

/* rtl/banked_memory_map_controller_core.sv */
// Path: an item goes through the memory read stage, then the output register to the
//   master side. Throughput: one item per cycle unless output or sweep stalls it;
//   each single-port memory serves one access per item.
// Reset: map state returns to bank 0x10, ROM selected, turbo on; then a clearing
//   pass zeroes main RAM and fills the boot ROM with 0xFF, during which no item is
//   accepted (configuration writes are taken throughout).
module banked_memory_map_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: turbo_mode
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] addr, [23:16] data
  input  logic [2:0]  s_axis_tuser,   // [2:0] op
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] read_data, [8] rom_selected, rest zero
);

  bmmc_pkg::bmmc_state_t state;
  bmmc_pkg::bmmc_cmd_t   cmd;

  logic       turbo_q;
  logic [7:0] bank_q;
  logic       rom_sel_q;

  logic                          clearing_q;
  logic [bmmc_pkg::MAIN_AW-1:0]  clr_cnt_q;

  logic                  s1_valid_q;
  bmmc_pkg::bmmc_src_e   s1_src_q;
  logic [7:0]            s1_byte_q;
  logic                  s1_rsel_q;
  logic                  s1_move;

  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic       out_rsel_q;
  logic [7:0] s1_data;

  logic       in_accept;

  logic [bmmc_pkg::MAIN_AW-1:0] main_addr;
  logic                         main_we;
  logic [7:0]                   main_wdata;
  logic [7:0]                   main_rdata;
  logic [bmmc_pkg::ROM_AW-1:0]  rom_addr;
  logic                         rom_we;
  logic [7:0]                   rom_wdata;
  logic [7:0]                   rom_rdata;
  logic [7:0]                   ext_rdata;
  logic                         rom_clr;

  // Handshakes
  assign cfg_ready_o   = 1'b1;
  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !clearing_q && (!s1_valid_q || s1_move);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Decode against the current map state
  assign state.turbo   = turbo_q;
  assign state.bank    = bank_q;
  assign state.rom_sel = rom_sel_q;

  bmmc_decode u_decode (
    .op_i    (s_axis_tuser),
    .addr_i  (s_axis_tdata[15:0]),
    .data_i  (s_axis_tdata[23:16]),
    .state_i (state),
    .cmd_o   (cmd)
  );

  // Hold map state; update on configuration and accepted io writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turbo_q   <= 1'b1;
      bank_q    <= bmmc_pkg::BANK_RESET;
      rom_sel_q <= 1'b1;
    end else begin
      if (cfg_valid_i && cfg_ready_o) turbo_q <= cfg_data_i;
      if (in_accept) begin
        if (cmd.bank_we) bank_q <= cmd.wdata;
        rom_sel_q <= cmd.rom_sel_nxt;
      end
    end
  end

  // Sweep main RAM and boot ROM after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (&clr_cnt_q) clearing_q <= 1'b0;
    end
  end

  assign rom_clr = 32'(clr_cnt_q) < bmmc_pkg::ROM_BYTES;

  // Memory port selection: sweep first, items afterwards
  always_comb begin
    if (clearing_q) begin
      main_addr  = clr_cnt_q;
      main_we    = 1'b1;
      main_wdata = '0;
      rom_addr   = bmmc_pkg::ROM_AW'(clr_cnt_q);
      rom_we     = rom_clr;
      rom_wdata  = bmmc_pkg::BYTE_NONE;
    end else begin
      main_addr  = cmd.main_addr;
      main_we    = in_accept && cmd.main_we;
      main_wdata = cmd.wdata;
      rom_addr   = cmd.rom_addr;
      rom_we     = in_accept && cmd.rom_we;
      rom_wdata  = cmd.wdata;
    end
  end

  bmmc_ram #(
    .AW    (bmmc_pkg::MAIN_AW),
    .DW    (8),
    .DEPTH (65536)
  ) u_main_ram (
    .clk_i   (clk_i),
    .addr_i  (main_addr),
    .we_i    (main_we),
    .wdata_i (main_wdata),
    .re_i    (in_accept),
    .rdata_o (main_rdata)
  );

  bmmc_ram #(
    .AW    (bmmc_pkg::ROM_AW),
    .DW    (8),
    .DEPTH (bmmc_pkg::ROM_BYTES)
  ) u_boot_rom (
    .clk_i   (clk_i),
    .addr_i  (rom_addr),
    .we_i    (rom_we),
    .wdata_i (rom_wdata),
    .re_i    (in_accept),
    .rdata_o (rom_rdata)
  );

  bmmc_ram #(
    .AW    (bmmc_pkg::EXT_AW),
    .DW    (8),
    .DEPTH (bmmc_pkg::EXT_BANKS * bmmc_pkg::HALF_BYTES)
  ) u_ext_ram (
    .clk_i   (clk_i),
    .addr_i  (cmd.ext_addr),
    .we_i    (in_accept && cmd.ext_we),
    .wdata_i (cmd.wdata),
    .re_i    (in_accept),
    .rdata_o (ext_rdata)
  );

  // Read stage: remember where the result comes from
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_src_q  <= cmd.src;
      s1_byte_q <= cmd.byte_val;
      s1_rsel_q <= cmd.rom_sel_nxt;
    end
  end

  // Select the result byte
  always_comb begin
    case (s1_src_q)
      bmmc_pkg::SRC_MAIN: s1_data = main_rdata;
      bmmc_pkg::SRC_ROM:  s1_data = rom_rdata;
      bmmc_pkg::SRC_EXT:  s1_data = ext_rdata;
      default:            s1_data = s1_byte_q;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q <= s1_data;
      out_rsel_q <= s1_rsel_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_rsel_q, out_data_q};

  // No item enters while the sweep runs
  a_no_accept_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s_axis_tready)
    else $error("item accepted during clearing pass");

  // A waiting read-stage item stays until the output register frees
  a_s1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |=> s1_valid_q)
    else $error("read-stage item lost while stalled");

  // The bank register changes only through an accepted item in turbo mode
  a_bank_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bank_q != $past(bank_q)) |-> $past(in_accept && turbo_q))
    else $error("bank register changed without a turbo io write");

endmodule

/* rtl/bmmc_ram.sv */
module bmmc_ram #(
  parameter int unsigned AW    = 16,
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic          clk_i,
  input  logic [AW-1:0] addr_i,
  input  logic          we_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Single port: write or registered read at one address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bmmc_decode.sv */
module bmmc_decode (
  input  logic [2:0]           op_i,
  input  logic [15:0]          addr_i,
  input  logic [7:0]           data_i,
  input  bmmc_pkg::bmmc_state_t state_i,
  output bmmc_pkg::bmmc_cmd_t   cmd_o
);

  logic [7:0]  page;
  logic        lower;
  logic        ext_map;
  logic [3:0]  bank_idx;
  logic        bank_ok;
  logic [14:0] rom_off;
  logic        rom_ok;
  logic        load_ok;

  // Address map terms
  always_comb begin
    page     = addr_i[15:8];
    lower    = !addr_i[15];
    ext_map  = state_i.turbo && !state_i.bank[bmmc_pkg::BANK_OFF_BIT];
    bank_idx = state_i.bank[3:0];
    bank_ok  = 32'(bank_idx) < bmmc_pkg::EXT_BANKS;
    // non-turbo ROM mirrors its first 4 KB
    rom_off  = state_i.turbo ? addr_i[14:0] : {3'b000, addr_i[11:0]};
    rom_ok   = 32'(rom_off) < bmmc_pkg::ROM_BYTES;
    load_ok  = 32'(addr_i) < bmmc_pkg::ROM_BYTES;
  end

  // Route the item to a store and pick the result source
  always_comb begin
    cmd_o             = '0;
    cmd_o.main_addr   = addr_i;
    cmd_o.rom_addr    = bmmc_pkg::ROM_AW'(rom_off);
    cmd_o.ext_addr    = bmmc_pkg::EXT_AW'({bank_idx, addr_i[14:0]});
    cmd_o.wdata       = data_i;
    cmd_o.rom_sel_nxt = state_i.rom_sel;
    cmd_o.src         = bmmc_pkg::SRC_BYTE;
    cmd_o.byte_val    = bmmc_pkg::BYTE_NONE;
    case (op_i)
      bmmc_pkg::OP_MEM_RD: begin
        if (!lower) begin
          cmd_o.src = bmmc_pkg::SRC_MAIN;
        end else if (ext_map) begin
          if (bank_ok) cmd_o.src = bmmc_pkg::SRC_EXT;
        end else if (state_i.rom_sel) begin
          if (rom_ok) cmd_o.src = bmmc_pkg::SRC_ROM;
        end else begin
          cmd_o.src = bmmc_pkg::SRC_MAIN;
        end
      end
      bmmc_pkg::OP_MEM_WR: begin
        if (lower && ext_map) begin
          cmd_o.ext_we = bank_ok;
        end else begin
          cmd_o.main_we = 1'b1;
        end
      end
      bmmc_pkg::OP_IO_WR: begin
        if (page == bmmc_pkg::PAGE_BANK) begin
          cmd_o.bank_we = state_i.turbo;
        end else if (page == bmmc_pkg::PAGE_ROM_ON) begin
          cmd_o.rom_sel_nxt = 1'b1;
        end else if (page == bmmc_pkg::PAGE_ROM_OFF) begin
          cmd_o.rom_sel_nxt = 1'b0;
        end
      end
      bmmc_pkg::OP_IO_RD: begin
        if (state_i.turbo && page == bmmc_pkg::PAGE_BANK) begin
          cmd_o.byte_val = state_i.bank;
        end
      end
      bmmc_pkg::OP_ROM_LD: begin
        cmd_o.rom_addr = bmmc_pkg::ROM_AW'(addr_i);
        cmd_o.rom_we   = load_ok;
      end
      default: begin
        cmd_o.src = bmmc_pkg::SRC_BYTE;
      end
    endcase
  end

endmodule
